[hdl/wstf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket text framer package
// Item types, header constants and the result batch shared by the framer.
// ----------------------------------------------------------------------------
package wstf_pkg;

  // Header byte constants.
  localparam logic [7:0] HDR_FIN_TEXT = 8'h81;
  localparam logic [6:0] HDR_LEN16    = 7'd126;

  // Deepest batch of results one item can cause: two fixed header bytes,
  // two extended length bytes and four key bytes.
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned COUNT_W     = $clog2(MAX_RESULTS + 1);

  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
    logic        mask_on;
    logic [31:0] mask_key;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
    logic       error;
  } out_item_t;

  // All results caused by one item; byte 0 goes out first. The end-of-frame
  // and error marks belong to the last byte of the batch only.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [COUNT_W-1:0]          count;
    logic                        last_eof;
    logic                        last_err;
  } batch_t;

endpackage

[hdl/wstf_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket text framer encoder
// Holds the open-frame state and turns one item into its batch of results.
// ----------------------------------------------------------------------------
module wstf_encoder
  import wstf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  output batch_t   batch
);

  logic [15:0] bytes_left, bytes_left_next;
  logic [1:0]  key_phase, key_phase_next;
  logic [31:0] held_key, held_key_next;
  logic        frame_open, frame_open_next;

  logic        long_len;
  logic [7:0]  key_byte;

  assign long_len = (item.frame_length >= {9'd0, HDR_LEN16});
  assign key_byte = held_key[{key_phase, 3'b000} +: 8];

  always_comb begin
    batch           = '0;
    bytes_left_next = bytes_left;
    key_phase_next  = key_phase;
    held_key_next   = held_key;
    frame_open_next = frame_open;
    case (item.opcode)
      OP_START: begin
        batch.bytes[0] = HDR_FIN_TEXT;
        if (long_len) begin
          batch.bytes[1] = {item.mask_on, HDR_LEN16};
          batch.bytes[2] = item.frame_length[15:8];
          batch.bytes[3] = item.frame_length[7:0];
          batch.bytes[4] = item.mask_key[7:0];
          batch.bytes[5] = item.mask_key[15:8];
          batch.bytes[6] = item.mask_key[23:16];
          batch.bytes[7] = item.mask_key[31:24];
        end else begin
          batch.bytes[1] = {item.mask_on, item.frame_length[6:0]};
          batch.bytes[2] = item.mask_key[7:0];
          batch.bytes[3] = item.mask_key[15:8];
          batch.bytes[4] = item.mask_key[23:16];
          batch.bytes[5] = item.mask_key[31:24];
        end
        batch.count = COUNT_W'(2) + (long_len ? COUNT_W'(2) : COUNT_W'(0))
                    + (item.mask_on ? COUNT_W'(4) : COUNT_W'(0));
        batch.last_eof  = (item.frame_length == 16'd0);
        held_key_next   = item.mask_on ? item.mask_key : 32'd0;
        key_phase_next  = 2'd0;
        bytes_left_next = item.frame_length;
        frame_open_next = (item.frame_length != 16'd0);
      end
      OP_PAYLOAD: begin
        batch.count = COUNT_W'(1);
        if (frame_open) begin
          batch.bytes[0]  = item.data_byte ^ key_byte;
          batch.last_eof  = (bytes_left == 16'd1);
          key_phase_next  = key_phase + 2'd1;
          bytes_left_next = bytes_left - 16'd1;
          frame_open_next = (bytes_left != 16'd1);
        end else begin
          // Payload with no open frame: a single error result, state kept.
          batch.last_err = 1'b1;
        end
      end
      default: begin
        batch = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      key_phase  <= '0;
      held_key   <= '0;
      frame_open <= 1'b0;
    end else if (accept) begin
      bytes_left <= bytes_left_next;
      key_phase  <= key_phase_next;
      held_key   <= held_key_next;
      frame_open <= frame_open_next;
    end
  end

endmodule

[hdl/websocket_text_framer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket text framer unit
// Encodes single-fragment WebSocket text frames one output byte at a time.
// ----------------------------------------------------------------------------
// Usage:
// The item channel (item_valid, item_stall, item) takes start items, which
// open a frame with its length, mask enable and key, and payload items that
// carry one byte each. The result channel (result_valid, result_stall,
// result) gives the encoded frame one byte per item, with end_of_frame on the
// last byte and error on a payload byte that arrived with no open frame.
// An accepted item is encoded at once into a batch buffer; the buffer feeds
// the output register one byte per cycle while the receiver does not stall.
// The first result of an item is registered in the buffer, then in the output register.
// A payload item causes one result, so payload bytes pass at one item per
// cycle while the receiver does not stall. A start item causes two to eight
// header bytes; the item channel is stalled until the last of them has moved
// into the output register.
// When the receiver stalls, the output register holds its result and the
// buffer backs up into item_stall. Reset clears the frame state, the buffer
// and the output register; no item is pending after reset.
// ----------------------------------------------------------------------------
module websocket_text_framer_unit
  import wstf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  logic   item_accept;
  logic   move;
  batch_t new_batch;
  batch_t buffer, buffer_next;
  logic   result_valid_next;
  out_item_t result_next;

  // The buffer hands its head byte on whenever the output register is free
  // or being emptied in this cycle.
  assign move = (buffer.count != '0) && (!result_valid || !result_stall);

  // A new item is taken only if the buffer is empty after this cycle, which
  // keeps results in item order.
  assign item_stall  = !((buffer.count == '0) ||
                         ((buffer.count == COUNT_W'(1)) && move));
  assign item_accept = item_valid && !item_stall;

  wstf_encoder u_encoder (
    .clk    (clk),
    .rst    (rst),
    .accept (item_accept),
    .item   (item),
    .batch  (new_batch)
  );

  always_comb begin
    buffer_next       = buffer;
    result_valid_next = result_valid;
    result_next       = result;
    if (move) begin
      result_valid_next        = 1'b1;
      result_next.out_byte     = buffer.bytes[0];
      result_next.end_of_frame = (buffer.count == COUNT_W'(1)) && buffer.last_eof;
      result_next.error        = (buffer.count == COUNT_W'(1)) && buffer.last_err;
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        buffer_next.bytes[i] = buffer.bytes[i+1];
      end
      buffer_next.bytes[MAX_RESULTS-1] = 8'd0;
      buffer_next.count = buffer.count - COUNT_W'(1);
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end
    if (item_accept) begin
      buffer_next = new_batch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer       <= '0;
      result_valid <= 1'b0;
      result       <= '0;
    end else begin
      buffer       <= buffer_next;
      result_valid <= result_valid_next;
      result       <= result_next;
    end
  end

  // The buffer never holds more than one item's worth of results.
  assert property (@(posedge clk) disable iff (rst)
    buffer.count <= COUNT_W'(MAX_RESULTS))
    else $error("result buffer overfilled");

  // A payload item leaves exactly one result in the buffer.
  assert property (@(posedge clk) disable iff (rst)
    (item_accept && item.opcode == OP_PAYLOAD) |=> (buffer.count == COUNT_W'(1)))
    else $error("payload item did not queue one result");

  // A start item queues at least the two fixed header bytes.
  assert property (@(posedge clk) disable iff (rst)
    (item_accept && item.opcode == OP_START) |=> (buffer.count >= COUNT_W'(2)))
    else $error("start item queued too few header bytes");

  // Error and end-of-frame never mark the same result.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.error && result.end_of_frame))
    else $error("result marked both error and end of frame");

endmodule
